// ===== rtl/core/mst_pkg.sv =====
// ----------------------------------------------------------------------------
// mst_pkg
// Types and constants shared by the interval timer slot chain.
// ----------------------------------------------------------------------------
package mst_pkg;

	localparam int SLOT_W      = 6;
	localparam int MAX_RESULTS = 8;
	localparam int NFIRE_W     = $clog2(MAX_RESULTS + 1);

	localparam logic [2:0] OP_INSTALL   = 3'd0;
	localparam logic [2:0] OP_UNINSTALL = 3'd1;
	localparam logic [2:0] OP_START     = 3'd2;
	localparam logic [2:0] OP_STOP      = 3'd3;
	localparam logic [2:0] OP_TICK      = 3'd4;
	localparam logic [2:0] OP_QUERY     = 3'd5;

	localparam logic KIND_REPLY = 1'b0;
	localparam logic KIND_FIRE  = 1'b1;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	// command token that walks the slot chain
	typedef struct packed {
		logic               vld;
		logic [2:0]         op;
		logic               ok;
		logic [SLOT_W-1:0]  idx;
		logic [31:0]        ivl;
		logic [7:0]         shots;
		logic [31:0]        now;
		logic               hit;
		logic               run;
		logic [31:0]        left;
		logic               pend;
		logic [SLOT_W-1:0]  pend_slot;
		logic [NFIRE_W-1:0] nfire;
	} token_t;

	typedef struct packed {
		logic              kind;
		logic              status;
		logic [SLOT_W-1:0] result_slot;
		logic              is_running;
		logic [31:0]       time_left_ms;
		logic              last;
	} res_t;

	typedef struct packed {
		logic req;
		res_t item;
	} emit_t;

endpackage

// ===== rtl/core/mst_cmd_if.sv =====
// ----------------------------------------------------------------------------
// mst_cmd_if
// Command channel: valid/ready with one timer command per transfer.
// ----------------------------------------------------------------------------
interface mst_cmd_if;
	logic               valid;
	logic               ready;
	logic [2:0]         operation;
	logic signed [7:0]  slot;
	logic [31:0]        interval_ms;
	logic [7:0]         shot_count;
	logic [31:0]        now_ms;

	modport source (output valid, operation, slot, interval_ms, shot_count, now_ms,
		input ready);
	modport sink (input valid, operation, slot, interval_ms, shot_count, now_ms,
		output ready);
endinterface

// ===== rtl/core/mst_rsp_if.sv =====
// ----------------------------------------------------------------------------
// mst_rsp_if
// Result channel: valid/ready with one reply or fire event per transfer.
// ----------------------------------------------------------------------------
interface mst_rsp_if;
	logic                       valid;
	logic                       ready;
	logic                       kind;
	logic                       status;
	logic [mst_pkg::SLOT_W-1:0] result_slot;
	logic                       is_running;
	logic [31:0]                time_left_ms;
	logic                       last;

	modport source (output valid, kind, status, result_slot, is_running, time_left_ms,
		last, input ready);
	modport sink (input valid, kind, status, result_slot, is_running, time_left_ms,
		last, output ready);
endinterface

// ===== rtl/core/mst_cell.sv =====
// ----------------------------------------------------------------------------
// mst_cell
// One timer slot: holds its state, acts on the passing command token and
// hands the token to the next slot.
// ----------------------------------------------------------------------------
module mst_cell #(
	parameter int IDX = 0
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             advance,
	input  mst_pkg::token_t  tok_in,
	output mst_pkg::token_t  tok_out,
	output mst_pkg::emit_t   emit
);

	logic        inst_q;
	logic        run_q;
	logic [31:0] last_q;
	logic [31:0] period_q;
	logic [7:0]  shots_q;

	mst_pkg::token_t tok_out_q;
	mst_pkg::token_t nxt;

	logic        match;
	logic        wrap;
	logic [31:0] elapsed;
	logic        do_install;
	logic        do_free;
	logic        do_start;
	logic        do_stop;
	logic        fire;
	logic        step;

	assign match   = tok_in.ok && (tok_in.idx == mst_pkg::SLOT_W'(IDX));
	// wrapped elapsed time is one less than the modular difference
	assign wrap    = last_q > tok_in.now;
	assign elapsed = tok_in.now - last_q - 32'(wrap);
	assign step    = advance && tok_in.vld;

	always_comb begin
		nxt        = tok_in;
		emit       = '0;
		do_install = 1'b0;
		do_free    = 1'b0;
		do_start   = 1'b0;
		do_stop    = 1'b0;
		fire       = 1'b0;
		if (tok_in.vld) begin
			unique case (tok_in.op)
				mst_pkg::OP_INSTALL: begin
					if (!tok_in.hit && !inst_q) begin
						do_install = 1'b1;
						nxt.hit    = 1'b1;
						nxt.idx    = mst_pkg::SLOT_W'(IDX);
					end
				end
				mst_pkg::OP_UNINSTALL: begin
					if (match) begin
						do_free = 1'b1;
						nxt.hit = 1'b1;
					end
				end
				mst_pkg::OP_START: begin
					if (match) begin
						do_start = 1'b1;
						nxt.hit  = 1'b1;
					end
				end
				mst_pkg::OP_STOP: begin
					if (match) begin
						do_stop = 1'b1;
						nxt.hit = 1'b1;
					end
				end
				mst_pkg::OP_QUERY: begin
					if (match) begin
						nxt.hit = 1'b1;
						nxt.run = run_q;
						if (run_q && (period_q > elapsed)) begin
							nxt.left = period_q - elapsed;
						end
					end
				end
				mst_pkg::OP_TICK: begin
					if (run_q && (elapsed >= period_q) &&
						(tok_in.nfire < mst_pkg::NFIRE_W'(mst_pkg::MAX_RESULTS))) begin
						fire          = 1'b1;
						nxt.pend      = 1'b1;
						nxt.pend_slot = mst_pkg::SLOT_W'(IDX);
						nxt.nfire     = tok_in.nfire + 1'b1;
						// the earlier fire is known not to be the final one
						if (tok_in.pend) begin
							emit.req              = 1'b1;
							emit.item.kind        = mst_pkg::KIND_FIRE;
							emit.item.status      = mst_pkg::STATUS_OK;
							emit.item.result_slot = tok_in.pend_slot;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inst_q    <= 1'b0;
			run_q     <= 1'b0;
			tok_out_q <= '0;
		end else if (advance) begin
			tok_out_q <= nxt;
			if (step) begin
				if (do_install) begin
					inst_q <= 1'b1;
					run_q  <= 1'b0;
				end
				if (do_free) begin
					inst_q <= 1'b0;
					run_q  <= 1'b0;
				end
				if (do_start) begin
					run_q <= 1'b1;
				end
				if (do_stop) begin
					run_q <= 1'b0;
				end
				if (fire && (shots_q == 8'd1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			if (do_start) begin
				period_q <= tok_in.ivl;
				shots_q  <= tok_in.shots;
				last_q   <= tok_in.now;
			end
			if (fire) begin
				last_q <= tok_in.now;
				if (shots_q != 8'd0) begin
					shots_q <= shots_q - 8'd1;
				end
			end
		end
	end

	assign tok_out = tok_out_q;

endmodule

// ===== rtl/core/multi_slot_interval_timer.sv =====
// ----------------------------------------------------------------------------
// multi_slot_interval_timer
// Table of SLOTS interval timers built as a row of slot cells. A command is
// taken into a head register and then walks the row, one cell per cycle
// unless the result channel holds off a pending transfer; each cell holds
// one slot's state and acts on the command as it passes. Install,
// uninstall, start, stop and query give one reply when the command leaves
// the last cell. A tick gives one fire event per due slot in slot order (at
// most eight), each sent once the next due slot is seen, the final one with
// last set. No new command is taken until the current one leaves the row.
// There is no clearing pass: slot period, shot count and fire time are only
// read after a start.
// ----------------------------------------------------------------------------
module multi_slot_interval_timer #(
	parameter int SLOTS = 8
) (
	input  logic     clk,
	input  logic     arst_n,
	mst_cmd_if.sink  cmd,
	mst_rsp_if.source rsp
);

	mst_pkg::token_t tok [SLOTS+1];
	mst_pkg::emit_t  emit_c [SLOTS];
	mst_pkg::token_t head_q;
	mst_pkg::token_t head_d;
	mst_pkg::token_t tail;
	mst_pkg::emit_t  tail_emit;
	mst_pkg::res_t   out_q;
	mst_pkg::res_t   emit_item;

	logic             busy_q;
	logic             out_vld_q;
	logic             out_free;
	logic             any_req;
	logic             advance;
	logic             accept;
	logic             slot_ok;
	logic [SLOTS:0]   tok_vld;

	assign accept   = cmd.valid && cmd.ready;
	assign cmd.ready = !busy_q;
	assign slot_ok  = !cmd.slot[7] && ($unsigned(cmd.slot) < 8'(SLOTS));

	always_comb begin
		head_d       = '0;
		head_d.vld   = 1'b1;
		head_d.op    = cmd.operation;
		head_d.ok    = slot_ok;
		head_d.idx   = slot_ok ? cmd.slot[mst_pkg::SLOT_W-1:0] : '0;
		head_d.ivl   = cmd.interval_ms;
		head_d.shots = cmd.shot_count;
		head_d.now   = cmd.now_ms;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q <= '0;
			busy_q <= 1'b0;
		end else begin
			if (accept) begin
				head_q <= head_d;
				busy_q <= 1'b1;
			end else if (advance) begin
				head_q.vld <= 1'b0;
			end
			if (tail.vld && advance) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign tok[0] = head_q;

	for (genvar i = 0; i < SLOTS; i++) begin : g_cell
		mst_cell #(
			.IDX (i)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.advance (advance),
			.tok_in  (tok[i]),
			.tok_out (tok[i+1]),
			.emit    (emit_c[i])
		);
	end

	assign tail = tok[SLOTS];

	// command leaves the row: final fire event or the command reply
	always_comb begin
		tail_emit = '0;
		if (tail.vld) begin
			if (tail.op == mst_pkg::OP_TICK) begin
				tail_emit.req              = tail.pend;
				tail_emit.item.kind        = mst_pkg::KIND_FIRE;
				tail_emit.item.status      = mst_pkg::STATUS_OK;
				tail_emit.item.result_slot = tail.pend ? tail.pend_slot : '0;
				tail_emit.item.last        = tail.pend;
			end else begin
				tail_emit.req               = 1'b1;
				tail_emit.item.kind         = mst_pkg::KIND_REPLY;
				tail_emit.item.status       = tail.hit ? mst_pkg::STATUS_OK
					: mst_pkg::STATUS_ERR;
				tail_emit.item.result_slot  = tail.hit ? tail.idx : '0;
				tail_emit.item.is_running   = tail.hit && tail.run;
				tail_emit.item.time_left_ms = tail.hit ? tail.left : '0;
				tail_emit.item.last         = 1'b1;
			end
		end
	end

	// only the cell holding the token can request, so the items are or-ed
	always_comb begin
		any_req   = tail_emit.req;
		emit_item = tail_emit.item;
		for (int i = 0; i < SLOTS; i++) begin
			any_req   = any_req | emit_c[i].req;
			emit_item = emit_item | emit_c[i].item;
		end
	end

	assign out_free = !out_vld_q || rsp.ready;
	assign advance  = !any_req || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (any_req && advance) begin
			out_vld_q <= 1'b1;
		end else if (rsp.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (any_req && advance) begin
			out_q <= emit_item;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.kind         = out_q.kind;
	assign rsp.status       = out_q.status;
	assign rsp.result_slot  = out_q.result_slot;
	assign rsp.is_running   = out_q.is_running;
	assign rsp.time_left_ms = out_q.time_left_ms;
	assign rsp.last         = out_q.last;

	always_comb begin
		for (int i = 0; i <= SLOTS; i++) begin
			tok_vld[i] = tok[i].vld;
		end
	end

`ifndef SYNTHESIS
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_vld))
		else $error("more than one command token in the slot row");

	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!busy_q |-> (tok_vld == '0))
		else $error("command token present while idle");

	a_req_busy: assert property (@(posedge clk) disable iff (!arst_n)
		any_req |-> busy_q)
		else $error("result requested with no command in flight");

	a_accept_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !cmd.ready)
		else $error("command channel ready right after a transfer");
`endif

endmodule
